// ----- sv/assert_macros.svh -----
// Assertion macros used by the codec top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> cons) \
    else $error("implication check failed");

// Next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error("next-cycle check failed");

`endif

// ----- sv/hsc_pkg.sv -----
// Types, constants and bit-mapping functions of the Hamming SEC codec
`timescale 1ns / 1ps
package hsc_pkg;

  localparam int WORD_W          = 63;
  localparam int SYN_W           = 6;
  localparam int PAR_W           = 3;
  localparam int MAX_PARITY_BITS = 6;
  localparam int MIN_PARITY_BITS = 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [SYN_W-1:0]  syn_t;
  typedef logic [PAR_W-1:0]  par_t;

  typedef enum logic {
    REQ_ENCODE = 1'b0,
    REQ_DECODE = 1'b1
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req_type;
  } ctl_t;

  function automatic logic is_pow2(int p);
    return (p & (p - 1)) == 0;
  endfunction

  // Place data bits, in order, at the non-parity positions
  function automatic word_t scatter(word_t data);
    word_t w;
    int    d;
    w = '0;
    d = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (!is_pow2(p)) begin
        w[p-1] = data[d];
        d++;
      end
    end
    return w;
  endfunction

  // Collect the non-parity positions into the low bits
  function automatic word_t gather(word_t w);
    word_t data;
    int    d;
    data = '0;
    d    = 0;
    for (int p = 1; p <= WORD_W; p++) begin
      if (!is_pow2(p)) begin
        data[d] = w[p-1];
        d++;
      end
    end
    return data;
  endfunction

  function automatic word_t cover_mask(int j);
    word_t m;
    m = '0;
    for (int p = 1; p <= WORD_W; p++) begin
      m[p-1] = ((p >> j) & 1) != 0;
    end
    return m;
  endfunction

  function automatic syn_t syndrome(word_t w);
    syn_t s;
    for (int j = 0; j < SYN_W; j++) begin
      s[j] = ^(w & cover_mask(j));
    end
    return s;
  endfunction

  function automatic par_t eff_r(par_t r);
    par_t e;
    e = r;
    if (r < par_t'(MIN_PARITY_BITS)) e = par_t'(MIN_PARITY_BITS);
    if (r > par_t'(MAX_PARITY_BITS)) e = par_t'(MAX_PARITY_BITS);
    return e;
  endfunction

  function automatic word_t low_mask(int len);
    word_t m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = i < len;
    end
    return m;
  endfunction

  function automatic word_t code_mask(par_t r);
    int n;
    n = (1 << r) - 1;
    return low_mask(n);
  endfunction

  function automatic word_t data_mask(par_t r);
    int k;
    k = (1 << r) - 1 - int'(r);
    return low_mask(k);
  endfunction

endpackage

// ----- sv/hsc_syn_stage.sv -----
// Syndrome stage: XOR trees over the positioned word
`timescale 1ns / 1ps
module hsc_syn_stage
  import hsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl_in,
  input  word_t word_in,
  output ctl_t  ctl_out,
  output word_t word_out,
  output syn_t  syn_out
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.req_type <= ctl_in.req_type;
    word_out         <= word_in;
    syn_out          <= syndrome(word_in);
  end

endmodule

// ----- sv/hsc_out_stage.sv -----
// Result stage: insert parity or correct and extract data
`timescale 1ns / 1ps
module hsc_out_stage
  import hsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  ctl_t  ctl_in,
  input  word_t word_in,
  input  syn_t  syn_in,
  output logic  done,
  output word_t out_word,
  output logic  corrected
);

  word_t enc_word;
  word_t flip;
  word_t dec_word;
  logic  syn_nz;

  always_comb begin
    enc_word = word_in;
    for (int j = 0; j < SYN_W; j++) begin
      enc_word[(1 << j) - 1] = syn_in[j];
    end
    syn_nz   = syn_in != '0;
    flip     = syn_nz ? (word_t'(1) << (syn_in - syn_t'(1))) : '0;
    dec_word = gather(word_in ^ flip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_in.valid;
    end
    if (ctl_in.req_type == REQ_DECODE) begin
      out_word  <= dec_word;
      corrected <= syn_nz;
    end else begin
      out_word  <= enc_word;
      corrected <= 1'b0;
    end
  end

endmodule

// ----- sv/hamming_sec_codec_core.sv -----
// Top level of the configurable Hamming single-error-correcting codec
// Usage:
//   Request channel: raise start with req_type and in_word; the request is
//   taken at a rising edge where start is high and busy is low. busy is
//   high only while rst is asserted, so one request can enter every cycle.
//   req_type encode places the low k data bits around the parity positions;
//   decode corrects a single flipped bit and returns the data bits.
//   Result channel: done pulses for one cycle with out_word and corrected.
//   done follows the edge that takes the request through the input
//   register, the syndrome stage and the result stage. Throughput is
//   one request per cycle, set by a three-stage pipeline (positioning and
//   masking, syndrome trees, parity insertion or correction and extraction).
//   The receiver cannot stall; results are never held back.
//   Configuration: cfg_we with cfg_wdata writes the parity count r; write
//   it only while no request is in flight. Values below 2 act as 2 and
//   above 6 as 6; code length is 2^r-1, data capacity 2^r-1-r.
//   Reset: synchronous rst drops requests in flight and sets r to 6.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hamming_sec_codec_core
  import hsc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              req_type,
  input  logic [WORD_W-1:0] in_word,
  input  logic              cfg_we,
  input  logic [PAR_W-1:0]  cfg_wdata,
  output logic              done,
  output logic [WORD_W-1:0] out_word,
  output logic              corrected
);

  par_t  parity_bits;
  par_t  r_eff;
  logic  accept;
  ctl_t  ctl1;
  word_t word1;
  ctl_t  ctl2;
  word_t word2;
  syn_t  syn2;

  assign busy   = rst;
  assign accept = start && !busy;
  assign r_eff  = eff_r(parity_bits);

  always_ff @(posedge clk) begin
    if (rst) begin
      parity_bits <= par_t'(MAX_PARITY_BITS);
    end else if (cfg_we) begin
      parity_bits <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
    end else begin
      ctl1.valid <= accept;
    end
    ctl1.req_type <= req_t'(req_type);
    if (req_type == REQ_DECODE) begin
      word1 <= in_word & code_mask(r_eff);
    end else begin
      word1 <= scatter(in_word & data_mask(r_eff));
    end
  end

  hsc_syn_stage u_syn (
    .clk      (clk),
    .rst      (rst),
    .ctl_in   (ctl1),
    .word_in  (word1),
    .ctl_out  (ctl2),
    .word_out (word2),
    .syn_out  (syn2)
  );

  hsc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (ctl2),
    .word_in   (word2),
    .syn_in    (syn2),
    .done      (done),
    .out_word  (out_word),
    .corrected (corrected)
  );

  `ASSERT_IMPLIES(a_latency, clk, rst, accept, ##3 done)
  `ASSERT_IMPLIES(a_no_spurious, clk, rst, done, $past(accept, 3))
  `ASSERT_NEXT(a_corr_decode, clk, rst, ctl2.valid && ctl2.req_type == REQ_ENCODE, !corrected)
  `ASSERT_IMPLIES(a_dec_width, clk, rst, done && corrected, out_word[WORD_W-1:WORD_W-SYN_W] == '0)

endmodule
